// ----- sv/split_scanner_led_effect_top_assert.svh -----
// ----------------------------------------------------------------------------
// Split scanner LED effect - assertion macros
// Property shorthands used by the top level to check the block's logic.
// All of them sample on aclk and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SPLIT_SCANNER_LED_EFFECT_TOP_ASSERT_SVH
`define SPLIT_SCANNER_LED_EFFECT_TOP_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define SSLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SSLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SSLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ssle_pkg.sv -----
// ----------------------------------------------------------------------------
// Split scanner LED effect - package
// Ring geometry, LED group sizes, constant divisors and shared types.
// ----------------------------------------------------------------------------
package ssle_pkg;

    localparam int LED_COUNT    = 12;
    localparam int DOT_COUNT    = 4;
    localparam int IDX_W        = 4;
    localparam int RING_SLOTS   = 16;
    localparam int SLOT_W       = 4;
    localparam int PHASE_W      = 13;
    localparam int STEP_MS      = 333;
    localparam int RING_MS      = 5328;
    localparam int HALF_RING_MS = 2664;
    localparam int REACH_MS     = 499;
    localparam int FALL_DEN     = 999;
    localparam int COLOR_W      = 8;
    localparam int WEIGHT_W     = 10;
    localparam int PROD_W       = COLOR_W + WEIGHT_W;

    // floor(x / 333) for x below 2^28 is (x * MOD_MUL) >> MOD_SHIFT.
    localparam int          DT_HI_W   = 28;
    localparam int          MOD_MUL_W = 29;
    localparam int          MOD_PROD_W = DT_HI_W + MOD_MUL_W;
    localparam int          MOD_SHIFT = 37;
    localparam int          QUOT_W    = MOD_PROD_W - MOD_SHIFT;
    localparam logic [28:0] MOD_MUL   = 29'd412729591;

    // floor(p / 999) for p below 2^18 is (p * DIV_MUL) >> DIV_SHIFT.
    localparam int          DIV_MUL_W = 19;
    localparam int          DIV_SHIFT = 28;
    localparam logic [18:0] DIV_MUL   = 19'd268705;

    // Configuration register indexes.
    localparam int         CFG_IDX_W = 2;
    localparam logic [1:0] CFG_RED   = 2'd0;
    localparam logic [1:0] CFG_GREEN = 2'd1;
    localparam logic [1:0] CFG_BLUE  = 2'd2;

    typedef struct packed {
        logic             dot;
        logic [IDX_W-1:0] hw;
    } ring_slot_t;

    // Ring position to LED: which group and which hardware index.
    localparam ring_slot_t RING_MAP [RING_SLOTS] = '{
        '{1'b0, 4'd0},  '{1'b0, 4'd2},  '{1'b1, 4'd0}, '{1'b0, 4'd4},
        '{1'b0, 4'd6},  '{1'b1, 4'd2},  '{1'b0, 4'd8}, '{1'b0, 4'd10},
        '{1'b0, 4'd11}, '{1'b0, 4'd9},  '{1'b1, 4'd3}, '{1'b0, 4'd7},
        '{1'b0, 4'd5},  '{1'b1, 4'd1},  '{1'b0, 4'd3}, '{1'b0, 4'd1}
    };

    // Frame handed from the phase unit to the pixel unit.
    typedef struct packed {
        logic               func;
        logic [PHASE_W-1:0] phase;
    } frame_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] pos;
    } slot_hit_t;

    // Ring position of an LED, looked up against the ring table.
    function automatic slot_hit_t find_slot(input logic dot, input logic [IDX_W-1:0] hw);
        slot_hit_t res;
        res = '0;
        for (int i = 0; i < RING_SLOTS; i++) begin
            if (RING_MAP[i].dot == dot && RING_MAP[i].hw == hw) begin
                res.found = 1'b1;
                res.pos   = SLOT_W'(i);
            end
        end
        return res;
    endfunction

    // Truncating division of a colour-weight product by the falloff denominator.
    function automatic logic [COLOR_W-1:0] div_fall(input logic [PROD_W-1:0] p);
        logic [PROD_W+DIV_MUL_W-1:0] t;
        t = (PROD_W+DIV_MUL_W)'(p) * (PROD_W+DIV_MUL_W)'(DIV_MUL);
        return t[DIV_SHIFT +: COLOR_W];
    endfunction

endpackage

// ----- sv/split_scanner_led_effect_top.sv -----
// ----------------------------------------------------------------------------
// Split scanner LED effect - top level
// A bright spot runs round a 16-position ring; each timestamped frame
// request yields one scaled colour per LED of the backlight or dot group.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transfer per frame request, s_tdata = now_ms and
//   s_tuser = frame kind (0 backlight, 1 dots).
//   m_ channel: one transfer per LED in hardware order, 12 for a backlight
//   frame and 4 for a dot frame, with m_tlast on the final LED.
//   cfg channel: writes the target colour (index 0 red, 1 green, 2 blue);
//   cfg_ready is always high, and writes belong between frames.
//   Path: the first LED of a frame reaches m_tdata through three phase
//   stages, a frame slot, the colour product stage and the division
//   stage. The pixel unit emits one LED per cycle while m_tready is high;
//   requests queue in the phase stages while it works through a frame,
//   and s_tready stays high while any of them is free.
//   Reset clears the stored time and the phase (the next request starts
//   the clock), sets the colour to white and empties every stage.
//   When m_tready is low the output holds and the pipeline stops behind it.
// ----------------------------------------------------------------------------
`include "split_scanner_led_effect_top_assert.svh"

module split_scanner_led_effect_top import ssle_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] now_ms
    input  logic                 s_tuser,   // [0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [3:0] led_index, [11:4] red,
                                            // [19:12] green, [27:20] blue, [31:28] zero
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    logic [COLOR_W-1:0] color_red_reg, color_green_reg, color_blue_reg;
    logic               frame_valid;
    logic               frame_ready;
    frame_t             frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_red_reg   <= '1;
            color_green_reg <= '1;
            color_blue_reg  <= '1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RED:   color_red_reg   <= cfg_data;
                CFG_GREEN: color_green_reg <= cfg_data;
                CFG_BLUE:  color_blue_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ssle_phase u_phase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_now      (s_tdata),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    ssle_pixel u_pixel (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .color_red   (color_red_reg),
        .color_green (color_green_reg),
        .color_blue  (color_blue_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // The phase handed on with a frame always lies within one lap.
    `SSLE_ASSERT_SAME(a_phase_in_lap, frame_valid, frame.phase < PHASE_W'(RING_MS), "phase out of lap")

    // The final LED of a frame is the top index of one of the two groups.
    `SSLE_ASSERT_SAME(a_last_index, m_tvalid && m_tlast, (m_tdata[3:0] == IDX_W'(LED_COUNT - 1)) || (m_tdata[3:0] == IDX_W'(DOT_COUNT - 1)), "tlast on wrong LED")

    // Within a frame the next LED follows at once with the next index.
    `SSLE_ASSERT_NEXT(a_led_sequence, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1), "LED sequence broken")

endmodule

// ----- sv/ssle_phase.sv -----
// ----------------------------------------------------------------------------
// Split scanner LED effect - phase unit
// Takes timestamps, reduces the elapsed time modulo one ring lap and
// accumulates the scan phase, one frame per transfer.
// ----------------------------------------------------------------------------
module ssle_phase import ssle_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_func,
    input  logic [31:0] in_now,
    output logic       frame_valid,
    input  logic       frame_ready,
    output frame_t     frame
);

    logic [31:0]            last_time_reg;
    logic [PHASE_W-1:0]     phase_reg;

    logic                   v0_reg, v1_reg, v2_reg;
    logic                   func0_reg, func1_reg, func2_reg;
    logic [31:0]            dt_reg;
    logic [MOD_PROD_W-1:0]  prod_reg;
    logic [DT_HI_W-1:0]     hi1_reg;
    logic [3:0]             lo1_reg;
    logic [PHASE_W-1:0]     r_reg;

    logic                   adv0, adv1, adv2;
    logic                   free1, free2;
    logic [31:0]            dt_next;
    logic [MOD_PROD_W-1:0]  prod_next;
    logic [QUOT_W-1:0]      quot;
    logic [DT_HI_W-1:0]     rem_raw;
    logic [DT_HI_W-1:0]     rem_fix;
    logic [PHASE_W-1:0]     r_next;
    logic [PHASE_W:0]       phase_sum;
    logic [PHASE_W-1:0]     phase_next;

    assign adv2     = v2_reg && frame_ready;
    assign free2    = !v2_reg || adv2;
    assign adv1     = v1_reg && free2;
    assign free1    = !v1_reg || adv1;
    assign adv0     = v0_reg && free1;
    assign in_ready = !v0_reg || adv0;

    // A zero stored time means no earlier item, so the phase stays put.
    assign dt_next   = (last_time_reg == 32'd0) ? 32'd0 : (in_now - last_time_reg);

    // The lap is 16 * 333 ms: the low four bits pass through and the rest
    // is reduced modulo 333.
    assign prod_next = MOD_PROD_W'(dt_reg[31:4]) * MOD_PROD_W'(MOD_MUL);

    always_comb begin
        quot    = prod_reg[MOD_SHIFT +: QUOT_W];
        rem_raw = hi1_reg - DT_HI_W'(DT_HI_W'(quot) * DT_HI_W'(STEP_MS));
        rem_fix = (rem_raw >= DT_HI_W'(STEP_MS)) ? rem_raw - DT_HI_W'(STEP_MS) : rem_raw;
        r_next  = {rem_fix[8:0], lo1_reg};
    end

    always_comb begin
        phase_sum  = {1'b0, phase_reg} + {1'b0, r_reg};
        phase_next = (phase_sum >= (PHASE_W+1)'(RING_MS))
                   ? PHASE_W'(phase_sum - (PHASE_W+1)'(RING_MS))
                   : PHASE_W'(phase_sum);
    end

    assign frame_valid = v2_reg;
    assign frame.func  = func2_reg;
    assign frame.phase = phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            phase_reg     <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                last_time_reg <= in_now;
            end
            if (adv2) begin
                phase_reg <= phase_next;
            end
            if (in_ready) begin
                v0_reg <= in_valid;
            end
            if (free1) begin
                v1_reg <= adv0;
            end
            if (free2) begin
                v2_reg <= adv1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            func0_reg <= in_func;
            dt_reg    <= dt_next;
        end
        if (adv0) begin
            func1_reg <= func0_reg;
            prod_reg  <= prod_next;
            hi1_reg   <= dt_reg[31:4];
            lo1_reg   <= dt_reg[3:0];
        end
        if (adv1) begin
            func2_reg <= func1_reg;
            r_reg     <= r_next;
        end
    end

endmodule

// ----- sv/ssle_pixel.sv -----
// ----------------------------------------------------------------------------
// Split scanner LED effect - pixel unit
// Walks a frame's LEDs in hardware order, one per cycle unless the output
// stalls, scaling the colour by the triangular falloff round the scan phase.
// ----------------------------------------------------------------------------
module ssle_pixel import ssle_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frame_valid,
    output logic               frame_ready,
    input  frame_t             frame,
    input  logic [COLOR_W-1:0] color_red,
    input  logic [COLOR_W-1:0] color_green,
    input  logic [COLOR_W-1:0] color_blue,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tlast
);

    logic                fr_valid_reg;
    logic                fr_func_reg;
    logic [PHASE_W-1:0]  fr_phase_reg;
    logic [IDX_W-1:0]    idx_reg;

    logic                e1_valid_reg;
    logic [IDX_W-1:0]    e1_idx_reg;
    logic                e1_last_reg;
    logic [PROD_W-1:0]   e1_r_reg, e1_g_reg, e1_b_reg;

    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_last_reg;
    logic [COLOR_W-1:0]  out_r_reg, out_g_reg, out_b_reg;

    logic                en;
    logic                issue;
    logic                last_led;
    logic                fr_done;
    logic [IDX_W-1:0]    count;
    slot_hit_t           hit;
    logic [PHASE_W-1:0]  pos_ms;
    logic [PHASE_W-1:0]  diff;
    logic [PHASE_W-1:0]  ring_dist;
    logic                lit;
    logic [WEIGHT_W-1:0] weight;

    assign en          = !out_valid_reg || m_tready;
    assign issue       = en && fr_valid_reg;
    assign count       = fr_func_reg ? IDX_W'(DOT_COUNT) : IDX_W'(LED_COUNT);
    assign last_led    = (idx_reg == count - IDX_W'(1));
    assign fr_done     = issue && last_led;
    assign frame_ready = !fr_valid_reg || fr_done;

    // Distance from the LED's ring position to the phase, the short way round.
    always_comb begin
        hit       = find_slot(fr_func_reg, idx_reg);
        pos_ms    = PHASE_W'(hit.pos) * PHASE_W'(STEP_MS);
        diff      = (fr_phase_reg >= pos_ms) ? fr_phase_reg - pos_ms : pos_ms - fr_phase_reg;
        ring_dist = (diff > PHASE_W'(HALF_RING_MS)) ? PHASE_W'(RING_MS) - diff : diff;
        lit       = hit.found && (ring_dist <= PHASE_W'(REACH_MS));
        weight    = lit ? WEIGHT_W'(FALL_DEN) - {ring_dist[8:0], 1'b0} : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (frame_valid && frame_ready) begin
                fr_valid_reg <= 1'b1;
                idx_reg      <= '0;
            end else if (fr_done) begin
                fr_valid_reg <= 1'b0;
                idx_reg      <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (en) begin
                e1_valid_reg  <= issue;
                out_valid_reg <= e1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_valid && frame_ready) begin
            fr_func_reg  <= frame.func;
            fr_phase_reg <= frame.phase;
        end
        if (issue) begin
            e1_idx_reg  <= idx_reg;
            e1_last_reg <= last_led;
            e1_r_reg    <= PROD_W'(color_red) * PROD_W'(weight);
            e1_g_reg    <= PROD_W'(color_green) * PROD_W'(weight);
            e1_b_reg    <= PROD_W'(color_blue) * PROD_W'(weight);
        end
        if (en && e1_valid_reg) begin
            out_idx_reg  <= e1_idx_reg;
            out_last_reg <= e1_last_reg;
            out_r_reg    <= div_fall(e1_r_reg);
            out_g_reg    <= div_fall(e1_g_reg);
            out_b_reg    <= div_fall(e1_b_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_b_reg, out_g_reg, out_r_reg, out_idx_reg};

endmodule
